FILE: design/indexed_ordered_list_macros.svh
// ---------------------------------------------------------------------------
// Indexed ordered list assertion macros
// Shared property forms for the checker that watches the top-level ports.
// ---------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_MACROS_SVH
`define INDEXED_ORDERED_LIST_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define IOL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed_ordered_list: same-cycle check failed");

// Next-cycle implication, clocked on clk, quiet while rst_n is low.
`define IOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed_ordered_list: next-cycle check failed");

`endif

FILE: design/iol_pkg.sv
// ---------------------------------------------------------------------------
// Indexed ordered list package
// Request and status codes, sequencer states and the cell command struct.
// ---------------------------------------------------------------------------
package iol_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_APPLY = 3'b100
  } state_e_t;

  // Broadcast to every cell in the update cycle.
  typedef struct packed {
    logic ins;  // open a slot at the position and write the new item
    logic rem;  // close the slot at the position
  } cell_cmd_t;

endpackage

FILE: design/iol_if.sv
// ---------------------------------------------------------------------------
// Indexed ordered list channel interfaces
// Valid/ready request and response channels with their payloads.
// ---------------------------------------------------------------------------
interface iol_req_if #(
  parameter int PW = 5,
  parameter int IW = 32
);
  logic          valid;
  logic          ready;
  logic [1:0]    op;
  logic [PW-1:0] position;
  logic [IW-1:0] item_in;

  modport source (output valid, output op, output position, output item_in, input ready);
  modport sink   (input valid, input op, input position, input item_in, output ready);
endinterface

interface iol_rsp_if #(
  parameter int FW = 4,
  parameter int CW = 5,
  parameter int IW = 32
);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [FW-1:0] found_position;
  logic [IW-1:0] item_out;
  logic [CW-1:0] count;
  logic          is_empty;

  modport source (output valid, output status, output found_position, output item_out,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input found_position, input item_out,
                  input count, input is_empty, output ready);
endinterface

FILE: design/indexed_ordered_list.sv
// ---------------------------------------------------------------------------
// Indexed ordered list
// Ordered store of up to DEPTH items with insert, remove, search and read.
// ---------------------------------------------------------------------------
// Each request passes through the transfer edge, a lookup cycle in which
// every cell compares its entry against the key and offers its entry if it
// sits at the requested position (both registered), and an update cycle in
// which the cells shift together, the count moves and the result is loaded
// into the output register. The next request is accepted in the cycle after
// the update, so the lookup/update sequencer takes one request at a time.
// The result register lets a new request enter while the previous result
// still waits; the update cycle holds only if that result has not been taken
// yet. Entries are not cleared at reset; only positions below the count are
// ever read or matched.
// ---------------------------------------------------------------------------
module indexed_ordered_list
  import iol_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  iol_req_if.sink   in_req,
  iol_rsp_if.source out_rsp
);

  localparam int PW = $clog2(DEPTH + 1);  // position and count width
  localparam int FW = $clog2(DEPTH);      // found position width
  localparam int IW = ITEM_WIDTH;
  localparam logic [PW-1:0] FULL_COUNT = PW'(DEPTH);

  // Sequencer and captured request
  state_e_t      state_r, state_nxt;
  op_e_t         op_r;
  logic [PW-1:0] pos_r;
  logic [IW-1:0] item_r;
  logic [PW-1:0] count_r, count_nxt;

  // Lookup results
  logic [DEPTH-1:0] match_r;
  logic [IW-1:0]    sel_item_r;

  // Output register
  logic          out_valid_r;
  status_e_t     out_status_r, status_nxt;
  logic [FW-1:0] out_found_r, found_nxt;
  logic [IW-1:0] out_item_r, item_out_nxt;
  logic [PW-1:0] out_count_r;

  // Cell chain
  cell_cmd_t        cmd;
  logic [IW-1:0]    cell_data [DEPTH];
  logic [IW-1:0]    cell_sel  [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [IW-1:0]    sel_item;

  logic          first_found;
  logic [FW-1:0] first_index;

  logic in_xfer;
  logic advance;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_xfer      = in_req.valid && in_req.ready;
  // Update only when the output register is free or being emptied.
  assign advance      = (state_r == S_APPLY) && (!out_valid_r || out_rsp.ready);

  // -------------------------------------------------------------------------
  // Cells: each one sees its left and right neighbor. The first cell takes
  // zero from the left (never used, insert at 0 writes the new item there);
  // the last cell keeps its own entry on a remove.
  // -------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [IW-1:0] left_w;
    logic [IW-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    iol_cell #(
      .INDEX (g),
      .PW    (PW),
      .IW    (IW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_r),
      .count      (count_r),
      .item       (item_r),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g]),
      .match      (cell_match[g]),
      .sel_data   (cell_sel[g])
    );
  end

  // Only one cell offers a nonzero entry, so an OR tree selects it.
  always_comb begin
    sel_item = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_item = sel_item | cell_sel[i];
    end
  end

  iol_first_match #(
    .DEPTH (DEPTH),
    .FW    (FW)
  ) u_first (
    .match (match_r),
    .found (first_found),
    .index (first_index)
  );

  // -------------------------------------------------------------------------
  // Result and cell command for the update cycle
  // -------------------------------------------------------------------------
  always_comb begin
    status_nxt   = ST_OK;
    found_nxt    = '0;
    item_out_nxt = '0;
    count_nxt    = count_r;
    cmd          = '0;

    unique case (op_r)
      OP_INSERT: begin
        if (pos_r > count_r) begin
          status_nxt = ST_RANGE;
        end else if (count_r == FULL_COUNT) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = advance;
          count_nxt = count_r + PW'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_r >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          item_out_nxt = sel_item_r;
          cmd.rem      = advance;
          count_nxt    = count_r - PW'(1);
        end
      end
      OP_SEARCH: begin
        if (first_found) begin
          found_nxt = first_index;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      OP_READ: begin
        if (pos_r >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          item_out_nxt = sel_item_r;
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer: idle -> lookup -> update, hold in update while the result
  // register is still occupied.
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (advance) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        // Drop the result once it has been transferred.
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= op_e_t'(in_req.op);
      pos_r  <= in_req.position;
      item_r <= in_req.item_in;
    end
    if (state_r == S_LOOK) begin
      match_r    <= cell_match;
      sel_item_r <= sel_item;
    end
    if (advance) begin
      out_status_r <= status_nxt;
      out_found_r  <= found_nxt;
      out_item_r   <= item_out_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.found_position = out_found_r;
  assign out_rsp.item_out       = out_item_r;
  assign out_rsp.count          = out_count_r;
  assign out_rsp.is_empty       = (out_count_r == '0);

endmodule

FILE: design/iol_cell.sv
// ---------------------------------------------------------------------------
// Indexed ordered list cell
// Holds one entry, shifts with its neighbors, compares and selects locally.
// ---------------------------------------------------------------------------
module iol_cell
  import iol_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int PW    = 5,
  parameter int IW    = 32
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [PW-1:0] pos,
  input  logic [PW-1:0] count,
  input  logic [IW-1:0] item,
  input  logic [IW-1:0] left_data,
  input  logic [IW-1:0] right_data,
  output logic [IW-1:0] data,
  output logic          match,
  output logic [IW-1:0] sel_data
);

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic [IW-1:0] data_r;
  logic [IW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (IDX == pos) begin
        data_nxt = item;
      end else if (IDX > pos) begin
        data_nxt = left_data;
      end
    end else if (cmd.rem) begin
      if (IDX >= pos) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign match    = (IDX < count) && (data_r == item);
  assign sel_data = (IDX == pos) ? data_r : '0;

endmodule

FILE: design/iol_first_match.sv
// ---------------------------------------------------------------------------
// Indexed ordered list first-match encoder
// Isolates the lowest set match bit and encodes its position.
// ---------------------------------------------------------------------------
module iol_first_match
  import iol_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int FW    = 4
) (
  input  logic [DEPTH-1:0] match,
  output logic             found,
  output logic [FW-1:0]    index
);

  logic [DEPTH-1:0] lowest;

  // Two's complement trick keeps only the lowest set bit.
  assign lowest = match & (~match + DEPTH'(1));
  assign found  = |match;

  always_comb begin
    index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      index = index | (lowest[i] ? FW'(i) : FW'(0));
    end
  end

endmodule

FILE: design/iol_checker.sv
// ---------------------------------------------------------------------------
// Indexed ordered list port checker
// Watches the top-level channels and flags inconsistent responses.
// ---------------------------------------------------------------------------
`include "indexed_ordered_list_macros.svh"

module iol_checker
  import iol_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic [$clog2(DEPTH)-1:0]     out_found,
  input logic [ITEM_WIDTH-1:0]        out_item,
  input logic [$clog2(DEPTH+1)-1:0]   out_count,
  input logic                         out_is_empty
);

  localparam int PW = $clog2(DEPTH + 1);

  // A stalled result stays offered.
  `IOL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // One request at a time: no transfer right after a transfer.
  `IOL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  // Count stays within capacity and the empty flag follows it.
  `IOL_ASSERT_NOW(a_count_ok, out_valid,
                  (out_count <= PW'(DEPTH)) && (out_is_empty == (out_count == '0)))
  // A failed request carries neither a position nor an item.
  `IOL_ASSERT_NOW(a_fail_clean, out_valid && (out_status != ST_OK),
                  (out_found == '0) && (out_item == '0))

endmodule

bind indexed_ordered_list iol_checker #(
  .DEPTH      (DEPTH),
  .ITEM_WIDTH (ITEM_WIDTH)
) u_iol_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_status   (out_rsp.status),
  .out_found    (out_rsp.found_position),
  .out_item     (out_rsp.item_out),
  .out_count    (out_rsp.count),
  .out_is_empty (out_rsp.is_empty)
);
